[hw/rtl/mics_pkg.sv]
`timescale 1ns / 1ps
package mics_pkg;

  localparam logic [31:0] BOOT_ADDR_DEFAULT = 32'hBFC0_0000;
  localparam logic [31:0] PHYS_MASK = 32'h1FFF_FFFF;

  localparam logic [2:0] MEM_NONE  = 3'd0;
  localparam logic [2:0] MEM_RD_B  = 3'd1;
  localparam logic [2:0] MEM_RD_H  = 3'd2;
  localparam logic [2:0] MEM_RD_W  = 3'd3;
  localparam logic [2:0] MEM_WR_B  = 3'd4;
  localparam logic [2:0] MEM_WR_W  = 3'd5;

  localparam logic [3:0] F_NONE     = 4'd0;
  localparam logic [3:0] F_OVF      = 4'd1;
  localparam logic [3:0] F_JZERO    = 4'd2;
  localparam logic [3:0] F_MISPC    = 4'd3;
  localparam logic [3:0] F_BSLOT    = 4'd4;
  localparam logic [3:0] F_LDMIS    = 4'd5;
  localparam logic [3:0] F_STMIS    = 4'd6;
  localparam logic [3:0] F_UNHANDLED = 4'd7;
  localparam logic [3:0] F_ISO      = 4'd8;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [4:0] CP0_RS_MF = 5'd0;
  localparam logic [4:0] CP0_RS_MT = 5'd4;
  localparam logic [4:0] CP0_STATUS = 5'd12;

  localparam logic [1:0] LSZ_B = 2'd1;
  localparam logic [1:0] LSZ_H = 2'd2;
  localparam logic [1:0] LSZ_W = 2'd3;

  // core sequencing: read register file, then execute and write back
  typedef enum logic [0:0] {
    ST_READ,
    ST_EXEC
  } state_t;

  // one register-file write
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } wb_t;

endpackage

[hw/rtl/mics_regfile.sv]
`timescale 1ns / 1ps
// 32 x 32 register file, two synchronous read ports, one write port
module mics_regfile (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [4:0]    ra_addr,
  input  logic [4:0]    rb_addr,
  output logic [31:0]   ra_data,
  output logic [31:0]   rb_data,
  input  mics_pkg::wb_t wr
);
  import mics_pkg::*;

  logic [31:0] mem [32];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data registered; a same-cycle write is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ra_data <= (wr.en && wr.addr == ra_addr) ? wr.data : mem[ra_addr];
      rb_data <= (wr.en && wr.addr == rb_addr) ? wr.data : mem[rb_addr];
    end
  end

endmodule

[hw/rtl/mips_integer_core_subset.sv]
`timescale 1ns / 1ps
// MIPS-I integer core, reduced subset, with branch delay slots.
// Input channel (in_valid/in_stall): each beat is op/word:
// op 0 is the instruction word at the last fetch address, op 1 the data
// for a pending load. Every input beat yields exactly one output beat with
// fetch_addr, mem_kind, mem_addr, mem_wdata and fault.
// An instruction first reads its two source registers from the register file
// memory, then executes and writes back; no new input beat is taken until
// the previous one has executed. The register file read/write round trip
// sets this sequencing.
// A finished result sits in the output register; the next input beat is
// taken while it waits, and execute holds (input stays stalled) while the
// output register is still full and stalled as the next result completes.
// Reset (rst, synchronous): registers zero, cop0 zero, fetch restarts at
// 0xBFC00000 (BOOT_ADDR_DEFAULT). The register file and cop0 file
// are cleared by a pass over all 32 entries after reset, during which no input is taken.
// cfg channel writes a word-aligned fetch address and restarts fetch there.
// After a fault the core halts: every beat returns fetch_addr 0 and the
// fault code until reset.
module mips_integer_core_subset (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [31:0] word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] fetch_addr,
  output logic [2:0]  mem_kind,
  output logic [28:0] mem_addr,
  output logic [31:0] mem_wdata,
  output logic [3:0]  fault
);
  import mics_pkg::*;

  // architectural state
  logic [31:0] pc_reg, next_pc;
  logic [1:0]  delay_flags;
  logic        load_pending;
  logic [4:0]  load_dest;
  logic [1:0]  load_size;
  logic [3:0]  halted_code;
  logic [31:0] cop0 [32];

  // clearing pass
  logic        clr_busy;
  logic [4:0]  clr_cnt;

  state_t      state, state_next;
  logic        x_op;
  logic [31:0] x_word;

  logic [31:0] ra, rb;
  wb_t         wb, rf_wr;

  logic        out_full;
  logic        fire_in;
  logic        done;

  assign cfg_ready = 1'b1;

  // new beat is taken in READ once the clearing pass is over
  assign in_stall = clr_busy || state != ST_READ;
  assign fire_in  = in_valid && !in_stall;
  assign done     = state == ST_EXEC && (!out_full || !out_stall);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_READ: if (fire_in) state_next = ST_EXEC;
      ST_EXEC: if (done) state_next = ST_READ;
      default: state_next = ST_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READ;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      x_op   <= op;
      x_word <= word;
    end
  end

  assign rf_wr = clr_busy ? '{en: 1'b1, addr: clr_cnt, data: 32'd0} : wb;

  mics_regfile u_rf (
    .clk     (clk),
    .rd_en   (fire_in),
    .ra_addr (word[25:21]),
    .rb_addr (word[20:16]),
    .ra_data (ra),
    .rb_data (rb),
    .wr      (rf_wr)
  );

  // decode and execute
  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, addr, sum_i, cop0_rd;
  logic        iso;
  logic [31:0] r_fetch, r_wdata;
  logic [2:0]  r_kind;
  logic [28:0] r_addr;
  logic [3:0]  f;
  logic        is_br, br_taken, br_slot;
  logic [31:0] br_target;
  logic [4:0]  link;
  logic        exec_instr;
  logic [31:0] npc_seq, pc_seq;

  assign opc  = x_word[31:26];
  assign rs   = x_word[25:21];
  assign rt   = x_word[20:16];
  assign rd   = x_word[15:11];
  assign sh   = x_word[10:6];
  assign fn   = x_word[5:0];
  assign imm  = x_word[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign addr = ra + simm;
  assign sum_i = ra + simm;
  assign iso  = cop0[CP0_STATUS][16];
  assign cop0_rd = cop0[rd];
  assign exec_instr = halted_code == F_NONE && !x_op && !load_pending;
  assign pc_seq  = next_pc;
  assign npc_seq = next_pc + 32'd4;
  assign br_slot = delay_flags[1];

  always_comb begin
    wb        = '{en: 1'b0, addr: rt, data: 32'd0};
    f         = F_NONE;
    r_kind    = MEM_NONE;
    r_addr    = addr[28:0];
    r_wdata   = 32'd0;
    is_br     = 1'b0;
    br_taken  = 1'b0;
    br_target = 32'd0;
    link      = 5'd0;
    unique case (opc)
      OP_SPECIAL: begin
        wb.addr = rd;
        unique case (fn)
          FN_SLL:  begin wb.en = 1'b1; wb.data = rb << sh; end
          FN_JR:   begin is_br = 1'b1; br_taken = 1'b1; br_target = ra; end
          FN_ADDU: begin wb.en = 1'b1; wb.data = ra + rb; end
          FN_AND:  begin wb.en = 1'b1; wb.data = ra & rb; end
          FN_OR:   begin wb.en = 1'b1; wb.data = ra | rb; end
          FN_SLT:  begin wb.en = 1'b1; wb.data = {31'd0, $signed(ra) < $signed(rb)}; end
          FN_SLTU: begin wb.en = 1'b1; wb.data = {31'd0, ra < rb}; end
          default: f = F_UNHANDLED;
        endcase
      end
      OP_J, OP_JAL: begin
        is_br = 1'b1; br_taken = 1'b1;
        // region bits come from the advanced pc
        br_target = {pc_seq[31:28], x_word[25:0], 2'b00};
        if (opc == OP_JAL) link = 5'd31;
      end
      OP_BEQ, OP_BNE: begin
        is_br = 1'b1;
        br_taken = (opc == OP_BEQ) ? (ra == rb) : (ra != rb);
        br_target = pc_seq + {simm[29:0], 2'b00};
      end
      OP_ADDI: begin
        if (~(ra[31] ^ simm[31]) & (ra[31] ^ sum_i[31])) f = F_OVF;
        else begin wb.en = 1'b1; wb.data = sum_i; end
      end
      OP_ADDIU: begin wb.en = 1'b1; wb.data = sum_i; end
      OP_SLTI:  begin wb.en = 1'b1; wb.data = {31'd0, $signed(ra) < $signed(simm)}; end
      OP_ANDI:  begin wb.en = 1'b1; wb.data = ra & {16'd0, imm}; end
      OP_ORI:   begin wb.en = 1'b1; wb.data = ra | {16'd0, imm}; end
      OP_LUI:   begin wb.en = 1'b1; wb.data = {imm, 16'd0}; end
      OP_COP0: begin
        if (rs == CP0_RS_MF) begin wb.en = 1'b1; wb.data = cop0_rd; end
        else if (rs != CP0_RS_MT) f = F_UNHANDLED;
      end
      OP_LB, OP_LH, OP_LW: begin
        if (opc == OP_LH && addr[0]) f = F_LDMIS;
        else if (opc == OP_LW && addr[1:0] != 2'b00) f = F_LDMIS;
        else if (iso) f = F_ISO;
        else r_kind = (opc == OP_LB) ? MEM_RD_B : (opc == OP_LH) ? MEM_RD_H : MEM_RD_W;
      end
      OP_SB: begin
        if (iso && addr[31:28] == 4'd0) f = F_ISO;
        else begin r_kind = MEM_WR_B; r_wdata = {24'd0, rb[7:0]}; end
      end
      OP_SW: begin
        if (iso && addr[31:28] == 4'd0) r_kind = MEM_NONE;
        else if (addr[1:0] != 2'b00) f = F_STMIS;
        else begin r_kind = MEM_WR_W; r_wdata = rb; end
      end
      default: f = F_UNHANDLED;
    endcase
    // branch checks
    if (is_br) begin
      if (br_slot) f = F_BSLOT;
      else begin
        wb = '{en: 1'b1, addr: link, data: npc_seq};
        if (br_taken && br_target == 32'd0) f = F_JZERO;
        else if (br_taken && br_target[1:0] != 2'b00) f = F_MISPC;
      end
    end
    if (r_kind == MEM_NONE) r_addr = 29'd0;
    // load data beat
    if (halted_code == F_NONE && x_op && load_pending) begin
      wb.en   = 1'b1;
      wb.addr = load_dest;
      unique case (load_size)
        LSZ_B:   wb.data = {{24{x_word[7]}}, x_word[7:0]};
        LSZ_H:   wb.data = {{16{x_word[15]}}, x_word[15:0]};
        default: wb.data = x_word;
      endcase
    end else if (!exec_instr || f != F_NONE) begin
      wb.en = 1'b0;
    end
    if (wb.addr == 5'd0 || !done) wb.en = 1'b0;
  end

  // pc sequencing and control state
  logic [31:0] pc_after, npc_after;
  assign pc_after  = pc_seq;
  assign npc_after = (is_br && br_taken) ? br_target : npc_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_reg       <= BOOT_ADDR_DEFAULT;
      next_pc      <= BOOT_ADDR_DEFAULT + 32'd4;
      delay_flags  <= 2'd0;
      load_pending <= 1'b0;
      load_dest    <= 5'd0;
      load_size    <= 2'd0;
      halted_code  <= F_NONE;
      clr_busy     <= 1'b1;
      clr_cnt      <= 5'd0;
    end else begin
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 5'd1;
        if (clr_cnt == 5'd31) clr_busy <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        pc_reg  <= {cfg_data[31:2], 2'b00};
        next_pc <= {cfg_data[31:2], 2'b00} + 32'd4;
      end else if (done && halted_code == F_NONE) begin
        if (x_op) begin
          load_pending <= 1'b0;
        end else if (!load_pending) begin
          if (f != F_NONE) begin
            halted_code  <= f;
            load_pending <= 1'b0;
          end else begin
            pc_reg      <= pc_after;
            next_pc     <= npc_after;
            delay_flags <= {is_br, 1'b0};
            if (r_kind == MEM_RD_B || r_kind == MEM_RD_H || r_kind == MEM_RD_W) begin
              load_pending <= 1'b1;
              load_dest    <= rt;
              load_size    <= r_kind[1:0];
            end
          end
        end
      end
    end
  end

  // cop0 storage: cleared by the pass, written by MTC0
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      cop0[clr_cnt] <= 32'd0;
    end else if (done && exec_instr && f == F_NONE && opc == OP_COP0 && rs == CP0_RS_MT) begin
      cop0[rd] <= rb;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (done) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (halted_code != F_NONE) begin
        fetch_addr <= 32'd0; mem_kind <= MEM_NONE; mem_addr <= 29'd0;
        mem_wdata <= 32'd0; fault <= halted_code;
      end else if (!exec_instr) begin
        fetch_addr <= pc_reg; mem_kind <= MEM_NONE; mem_addr <= 29'd0;
        mem_wdata <= 32'd0; fault <= F_NONE;
      end else if (f != F_NONE) begin
        fetch_addr <= 32'd0; mem_kind <= MEM_NONE; mem_addr <= 29'd0;
        mem_wdata <= 32'd0; fault <= f;
      end else begin
        fetch_addr <= pc_after; mem_kind <= r_kind; mem_addr <= r_addr;
        mem_wdata <= r_wdata; fault <= F_NONE;
      end
    end
  end

  assign out_valid = out_full;

  // checks
  a_no_in_while_exec: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |-> !fire_in) else $error("input taken during execute");
  a_one_out_per_in: assert property (@(posedge clk) disable iff (rst)
    fire_in |=> state == ST_EXEC) else $error("input beat lost");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted_code != F_NONE |=> halted_code == $past(halted_code))
    else $error("halt code changed");
  a_no_load_when_halted: assert property (@(posedge clk) disable iff (rst)
    $rose(halted_code != F_NONE) |-> !load_pending)
    else $error("load pending after fault");

endmodule
